[hdl/lsmpq_pkg.sv]
// ----------------------------------------------------------------------------
// lsmpq_pkg
// Types and constants shared by the linear-scan min priority queue files.
// ----------------------------------------------------------------------------
package lsmpq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int KEY_MAX_W     = 64;
  localparam int KEY_IO_W      = 32;
  localparam int COUNT_W       = 5;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PEEK   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    func_t                func;
    logic [KEY_IO_W-1:0]  key_in;
  } req_t;

  typedef struct packed {
    logic [KEY_IO_W-1:0]  key_out;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } rsp_t;

endpackage

[hdl/linear_scan_min_priority_queue.sv]
// Add, unknown func, or remove/peek on empty: the result is decided in the exec state.
// Peek: after exec, scans the N stored entries (one compare per entry).
// Remove: scans as peek does; unless m, the index of the minimum, is last, the tail shifts one per cycle.
// One item at a time; busy is high from accept until the result is issued.
// Reset clears the state, the occupancy and done; the key RAM is not cleared and needs no sweep.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
// linear_scan_min_priority_queue
// Insertion-ordered key store with a single comparator scanning for the min.
// ----------------------------------------------------------------------------
module linear_scan_min_priority_queue #(
  parameter int DEPTH     = lsmpq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = lsmpq_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lsmpq_pkg::req_t   req,
  output logic              busy,
  output logic              done,
  output lsmpq_pkg::rsp_t   rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int KW = KEY_WIDTH;

  lsmpq_pkg::state_t state, state_next;
  lsmpq_pkg::req_t   req_r;

  logic [CW-1:0] occ, occ_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [KW-1:0] best_key, best_key_next;
  logic [AW-1:0] best_idx, best_idx_next;

  logic [KW-1:0] mem [DEPTH];
  logic [KW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_data;

  logic               fin;
  lsmpq_pkg::status_t fin_status;
  logic [KW-1:0]      fin_key;

  logic [CW-1:0] ptr_p1, ptr_p2, sel_p1;
  logic          scan_last, shift_last, need_shift, cand_better;
  logic [KW-1:0] sel_key;
  logic [AW-1:0] sel_idx;
  logic [lsmpq_pkg::KEY_MAX_W-1:0] key_in_wide, key_out_wide;
  logic [31:0]   cnt_wide;

  assign busy = (state != lsmpq_pkg::S_IDLE);

  // shared comparator and scan bookkeeping
  always_comb begin
    ptr_p1      = {1'b0, ptr} + CW'(1);
    ptr_p2      = {1'b0, ptr} + CW'(2);
    scan_last   = (ptr_p1 == occ);
    shift_last  = (ptr_p2 == occ);
    cand_better = (ptr == '0) || (rd_data < best_key);
    sel_key     = cand_better ? rd_data : best_key;
    sel_idx     = cand_better ? ptr : best_idx;
    sel_p1      = {1'b0, sel_idx} + CW'(1);
    need_shift  = (req_r.func == lsmpq_pkg::FUNC_REMOVE) && (sel_p1 != occ);
    key_in_wide = lsmpq_pkg::KEY_MAX_W'(req_r.key_in);
  end

  always_comb begin
    state_next = state;
    case (state)
      lsmpq_pkg::S_IDLE: begin
        if (start) state_next = lsmpq_pkg::S_EXEC;
      end
      lsmpq_pkg::S_EXEC: begin
        case (req_r.func)
          lsmpq_pkg::FUNC_REMOVE,
          lsmpq_pkg::FUNC_PEEK: begin
            state_next = (occ == '0) ? lsmpq_pkg::S_IDLE : lsmpq_pkg::S_SCAN;
          end
          default: state_next = lsmpq_pkg::S_IDLE;
        endcase
      end
      lsmpq_pkg::S_SCAN: begin
        if (scan_last) state_next = need_shift ? lsmpq_pkg::S_SHIFT : lsmpq_pkg::S_IDLE;
      end
      lsmpq_pkg::S_SHIFT: begin
        if (shift_last) state_next = lsmpq_pkg::S_IDLE;
      end
      default: state_next = lsmpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr       = ptr;
    we            = 1'b0;
    wr_addr       = ptr;
    wr_data       = rd_data;
    fin           = 1'b0;
    fin_status    = lsmpq_pkg::ST_OK;
    fin_key       = '0;
    occ_next      = occ;
    ptr_next      = ptr;
    best_key_next = best_key;
    best_idx_next = best_idx;
    case (state)
      lsmpq_pkg::S_EXEC: begin
        rd_addr  = '0;
        ptr_next = '0;
        case (req_r.func)
          lsmpq_pkg::FUNC_ADD: begin
            fin = 1'b1;
            if (occ >= CW'(DEPTH)) begin
              fin_status = lsmpq_pkg::ST_FULL;
            end else begin
              we       = 1'b1;
              wr_addr  = occ[AW-1:0];
              wr_data  = key_in_wide[KW-1:0];
              occ_next = occ + CW'(1);
            end
          end
          lsmpq_pkg::FUNC_REMOVE,
          lsmpq_pkg::FUNC_PEEK: begin
            if (occ == '0) begin
              fin        = 1'b1;
              fin_status = lsmpq_pkg::ST_EMPTY;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      lsmpq_pkg::S_SCAN: begin
        best_key_next = sel_key;
        best_idx_next = sel_idx;
        rd_addr       = ptr_p1[AW-1:0];
        ptr_next      = ptr_p1[AW-1:0];
        if (scan_last) begin
          if (need_shift) begin
            rd_addr  = sel_p1[AW-1:0];
            ptr_next = sel_idx;
          end else begin
            fin     = 1'b1;
            fin_key = sel_key;
            if (req_r.func == lsmpq_pkg::FUNC_REMOVE) occ_next = occ - CW'(1);
          end
        end
      end
      lsmpq_pkg::S_SHIFT: begin
        we       = 1'b1;
        wr_addr  = ptr;
        wr_data  = rd_data;
        rd_addr  = ptr_p2[AW-1:0];
        ptr_next = ptr_p1[AW-1:0];
        if (shift_last) begin
          fin      = 1'b1;
          fin_key  = best_key;
          occ_next = occ - CW'(1);
        end
      end
      default: ;
    endcase
    key_out_wide = lsmpq_pkg::KEY_MAX_W'(fin_key);
    cnt_wide     = 32'(occ_next);
  end

  // key RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsmpq_pkg::S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req_r <= req;
    ptr      <= ptr_next;
    best_key <= best_key_next;
    best_idx <= best_idx_next;
    if (fin) begin
      rsp.key_out <= key_out_wide[lsmpq_pkg::KEY_IO_W-1:0];
      rsp.status  <= fin_status;
      rsp.count   <= cnt_wide[lsmpq_pkg::COUNT_W-1:0];
    end
  end

endmodule

[hdl/lsmpq_checker.sv]
// ----------------------------------------------------------------------------
// lsmpq_checker
// Port-level checks for the linear-scan min priority queue.
// ----------------------------------------------------------------------------
module lsmpq_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input lsmpq_pkg::rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while busy");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("item finished without a result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == lsmpq_pkg::ST_EMPTY |-> rsp.count == '0 && rsp.key_out == '0)
    else $error("empty status with nonzero key or count");

endmodule

bind linear_scan_min_priority_queue lsmpq_checker u_lsmpq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

[sim/tb_linear_scan_min_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_linear_scan_min_priority_queue
// Self-checking bench for the linear-scan min priority queue. A directed
// block covers empty, full, unknown-op and extreme keys. Random add/remove/peek
// traffic then sweeps the store between empty and full. Every item is
// predicted by a local queue model, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_linear_scan_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import lsmpq_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  req_t pending_cmds[$];
  rsp_t expected_results[$];

  logic [KEY_IO_W-1:0] pq_keys[DEPTH_DEF];
  int unsigned         pq_len = 0;

  int n_accepted   = 0;
  int n_errors     = 0;
  int stall_cycles = 0;
  bit timed_out    = 1'b0;

  always #5 clk = ~clk;

  linear_scan_min_priority_queue u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  function automatic req_t mk_cmd(func_t f, logic [KEY_IO_W-1:0] k);
    req_t r;
    r.func   = f;
    r.key_in = k;
    return r;
  endfunction

  function automatic void append_cmd(req_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Queue model: insertion-ordered store, earliest key wins ties.
  function automatic rsp_t pq_apply(req_t r);
    rsp_t        o;
    int unsigned best;
    o.key_out = '0;
    o.status  = ST_OK;
    o.count   = '0;
    case (r.func)
      FUNC_ADD: begin
        if (pq_len >= DEPTH_DEF) begin
          o.status = ST_FULL;
        end else begin
          pq_keys[pq_len] = r.key_in;
          pq_len++;
        end
      end
      FUNC_REMOVE, FUNC_PEEK: begin
        if (pq_len == 0) begin
          o.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < pq_len; i++) begin
            if (pq_keys[i] < pq_keys[best]) best = i;
          end
          o.key_out = pq_keys[best];
          if (r.func == FUNC_REMOVE) begin
            for (int i = best; i + 1 < pq_len; i++) pq_keys[i] = pq_keys[i + 1];
            pq_len--;
          end
        end
      end
      default: ;
    endcase
    o.count = COUNT_W'(pq_len);
    return o;
  endfunction

  // Driver: hold an item until taken, random gaps between items, none while 250 to 349 are accepted.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), pq_apply(req));
        n_accepted++;
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() != 0 &&
            ((n_accepted >= 250 && n_accepted < 350) || $urandom_range(99) >= 29)) begin
          start <= 1'b1;
          req   <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: key_out=%h status=%0d count=%0d",
               rsp.key_out, rsp.status, rsp.count);
        n_errors++;
      end else begin
        exp_rsp = expected_results.pop_front();
        if (rsp.key_out !== exp_rsp.key_out) begin
          $error("key_out: expected %h, actual %h", exp_rsp.key_out, rsp.key_out);
          n_errors++;
        end
        if (rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
          n_errors++;
        end
        if (rsp.count !== exp_rsp.count) begin
          $error("count: expected %0d, actual %0d", exp_rsp.count, rsp.count);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    int                  bias;
    int                  roll;
    func_t               f;
    logic [KEY_IO_W-1:0] k;
    logic [KEY_IO_W-1:0] extremes[4];

    extremes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

    // directed: empty queue, unknown op, fill past full, then min selection
    append_cmd(mk_cmd(FUNC_PEEK, 32'hFFFF_FFFF));
    append_cmd(mk_cmd(FUNC_REMOVE, 32'h5555_5555));
    append_cmd(mk_cmd(func_t'(2'd3), 32'hAAAA_AAAA));
    append_cmd(mk_cmd(FUNC_ADD, 32'hFFFF_FFFF));
    append_cmd(mk_cmd(FUNC_ADD, 32'h0000_0005));
    append_cmd(mk_cmd(FUNC_ADD, 32'h0000_0000));
    append_cmd(mk_cmd(FUNC_ADD, 32'h0000_0005));
    append_cmd(mk_cmd(FUNC_ADD, 32'h8000_0000));
    append_cmd(mk_cmd(FUNC_ADD, 32'h0000_0000));
    for (int i = 0; i < 10; i++) append_cmd(mk_cmd(FUNC_ADD, $urandom));
    append_cmd(mk_cmd(FUNC_ADD, 32'h7FFF_FFFF));
    append_cmd(mk_cmd(FUNC_PEEK, 32'h0));
    append_cmd(mk_cmd(FUNC_REMOVE, 32'h0));
    append_cmd(mk_cmd(FUNC_REMOVE, 32'hFFFF_FFFF));
    append_cmd(mk_cmd(func_t'(2'd3), 32'h1234_5678));
    append_cmd(mk_cmd(FUNC_REMOVE, 32'h0));

    // random: phases biased toward filling, draining or balanced traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) bias = $urandom_range(2);
      roll = $urandom_range(99);
      if (roll >= 97) f = func_t'(2'd3);
      else if (bias == 0) f = (roll < 65) ? FUNC_ADD : (roll < 85) ? FUNC_REMOVE : FUNC_PEEK;
      else if (bias == 1) f = (roll < 30) ? FUNC_ADD : (roll < 80) ? FUNC_REMOVE : FUNC_PEEK;
      else f = (roll < 45) ? FUNC_ADD : (roll < 80) ? FUNC_REMOVE : FUNC_PEEK;
      case ($urandom_range(3))
        0:       k = $urandom_range(15);
        1:       k = extremes[$urandom_range(3)];
        default: k = $urandom;
      endcase
      append_cmd(mk_cmd(f, k));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        do @(negedge clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
      end
      begin
        wait (stall_cycles >= STALL_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out && expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_errors++;
    end
    if (!timed_out && n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
